### rtl/core/json_string_unescape_utf8_unit_assert.svh
// assertion macros used by the top-level rtl file
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH

// same-cycle implication on clk_i, off during reset
`define JSU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off during reset
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

  localparam int unsigned CP_W = 21;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } text_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      result_kind;
    logic       run_last;
  } result_item_t;

  // what one text byte leaves for the back end: an optional code point,
  // an optional byte or completion, and an optional error, in that order
  typedef struct packed {
    logic            cp_en;
    logic [CP_W-1:0] cp;
    logic            mid_en;
    logic            mid_done;
    logic [7:0]      mid_byte;
    logic            err_en;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

`default_nettype wire

### rtl/core/jsu_front.sv
`default_nettype none

module jsu_front import jsu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire text_item_t item_i,
  output logic            enq_o,
  output bundle_t         bundle_o
);

  typedef enum logic [6:0] {
    ST_SEEK   = 7'b0000001,
    ST_STR    = 7'b0000010,
    ST_ESC    = 7'b0000100,
    ST_HEX    = 7'b0001000,
    ST_PHI    = 7'b0010000,
    ST_PHI_BS = 7'b0100000,
    ST_LOHEX  = 7'b1000000
  } mode_e;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [5:0] HI_SURR   = 6'b110110;
  localparam logic [CP_W-1:0] CP_SUPP = 21'h10000;
  localparam logic [CP_W-1:0] CP_LOW  = 21'h0DC00;

  mode_e       mode_q, mode_d;
  logic [15:0] hex_q, hex_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  hi_q, hi_d;

  logic [7:0]  c;
  logic        last;
  logic [4:0]  dig;
  logic [15:0] acc_new;
  logic        esc_ok, esc_u;
  logic [7:0]  esc_val;
  logic        run_str, run_esc, fin;
  bundle_t     bnd;

  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] r;
    r = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, ch[3:0]};
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      r = {1'b1, ch[3:0] + 4'd9};
    end
    return r;
  endfunction

  assign c       = item_i.text_byte;
  assign last    = item_i.text_end;
  assign dig     = hex_digit(c);
  assign acc_new = {hex_q[11:0], dig[3:0]};

  always_comb begin
    esc_ok  = 1'b1;
    esc_u   = 1'b0;
    esc_val = c;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: esc_val = c;
      CH_B: esc_val = 8'h08;
      CH_F: esc_val = 8'h0C;
      CH_N: esc_val = 8'h0A;
      CH_R: esc_val = 8'h0D;
      CH_T: esc_val = 8'h09;
      CH_U: begin
        esc_ok = 1'b0;
        esc_u  = 1'b1;
      end
      default: esc_ok = 1'b0;
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    hex_d   = hex_q;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    bnd     = '0;
    run_str = 1'b0;
    run_esc = 1'b0;
    fin     = 1'b0;
    case (mode_q)
      ST_STR: run_str = 1'b1;
      ST_ESC: run_esc = 1'b1;
      ST_HEX, ST_LOHEX: begin
        if (!dig[4]) begin
          bnd.err_en = 1'b1;
          fin        = 1'b1;
          mode_d     = ST_SEEK;
        end else if (cnt_q == 2'd3) begin
          cnt_d = '0;
          hex_d = '0;
          if (mode_q == ST_LOHEX) begin
            // joined pair, the low half is taken as is
            bnd.cp_en = 1'b1;
            bnd.cp    = CP_SUPP + {1'b0, hi_q, 10'b0} + {5'b0, acc_new} - CP_LOW;
            mode_d    = ST_STR;
          end else if (acc_new[15:10] == HI_SURR) begin
            hi_d   = acc_new[9:0];
            mode_d = ST_PHI;
          end else begin
            bnd.cp_en = 1'b1;
            bnd.cp    = {5'b0, acc_new};
            mode_d    = ST_STR;
          end
        end else begin
          hex_d = acc_new;
          cnt_d = cnt_q + 2'd1;
        end
      end
      ST_PHI: begin
        if (c == CH_BSLASH && !last) begin
          mode_d = ST_PHI_BS;
        end else begin
          bnd.cp_en = 1'b1;
          bnd.cp    = {5'b0, HI_SURR, hi_q};
          run_str   = 1'b1;
        end
      end
      ST_PHI_BS: begin
        if (c == CH_U) begin
          mode_d = ST_LOHEX;
          hex_d  = '0;
          cnt_d  = '0;
        end else begin
          bnd.cp_en = 1'b1;
          bnd.cp    = {5'b0, HI_SURR, hi_q};
          run_esc   = 1'b1;
        end
      end
      default: begin
        if (c == CH_QUOTE) begin
          mode_d = ST_STR;
        end else if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)) begin
          bnd.err_en = 1'b1;
          fin        = 1'b1;
          mode_d     = ST_SEEK;
        end else begin
          mode_d = ST_SEEK;
        end
      end
    endcase

    if (run_str) begin
      if (c == CH_QUOTE) begin
        bnd.mid_en   = 1'b1;
        bnd.mid_done = 1'b1;
        fin          = 1'b1;
        mode_d       = ST_SEEK;
      end else if (c == CH_BSLASH) begin
        mode_d = ST_ESC;
      end else begin
        bnd.mid_en   = 1'b1;
        bnd.mid_byte = c;
        mode_d       = ST_STR;
      end
    end

    if (run_esc) begin
      if (esc_u) begin
        mode_d = ST_HEX;
        hex_d  = '0;
        cnt_d  = '0;
      end else if (esc_ok) begin
        bnd.mid_en   = 1'b1;
        bnd.mid_byte = esc_val;
        mode_d       = ST_STR;
      end else begin
        bnd.err_en = 1'b1;
        fin        = 1'b1;
        mode_d     = ST_SEEK;
      end
    end

    // text ran out before the string closed
    if (last && !fin) begin
      bnd.err_en = 1'b1;
      fin        = 1'b1;
      mode_d     = ST_SEEK;
    end

    if (fin) begin
      hex_d = '0;
      cnt_d = '0;
      hi_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ST_SEEK;
      hex_q  <= '0;
      cnt_q  <= '0;
      hi_q   <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      cnt_q  <= cnt_d;
      hi_q   <= hi_d;
    end
  end

  assign bundle_o = bnd;
  assign enq_o    = accept_i && (bnd.cp_en || bnd.mid_en || bnd.err_en);

endmodule

`default_nettype wire

### rtl/core/jsu_queue.sv
`default_nettype none

module jsu_queue import jsu_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    enq_i,
  input  wire bundle_t data_i,
  input  wire logic    deq_i,
  output bundle_t      head_o,
  output q_stat_t      stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bundle_t         entries_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   count_q;

  always_ff @(posedge clk_i) begin
    if (enq_i) begin
      entries_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (enq_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (deq_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (enq_i && !deq_i) begin
        count_q <= count_q + CW'(1);
      end else if (deq_i && !enq_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  assign head_o           = entries_q[rd_q];
  assign stat_o.full      = (count_q == CW'(DEPTH));
  assign stat_o.not_empty = (count_q != '0);

endmodule

`default_nettype wire

### rtl/core/jsu_back.sv
`default_nettype none

module jsu_back import jsu_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire bundle_t head_i,
  input  wire q_stat_t stat_i,
  output logic         deq_o,
  input  wire logic    pop_i,
  output logic         out_valid_o,
  output result_item_t result_o
);

  logic [2:0]   idx_q;
  logic         out_v_q;
  result_item_t out_q;

  logic [2:0]   ncp, cp_slots, total;
  logic         pop_fire, load, at_last;
  result_item_t res;

  // utf-8 byte k of a sequence of n bytes
  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                           input logic [2:0] n,
                                           input logic [2:0] k);
    logic [7:0] r;
    logic [2:0] p;
    p = n - 3'd1 - k;
    r = {2'b10, cp[5:0]};
    if (k == 3'd0) begin
      case (n)
        3'd1:    r = cp[7:0];
        3'd2:    r = {3'b110, cp[10:6]};
        3'd3:    r = {4'b1110, cp[15:12]};
        default: r = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (p)
        3'd1:    r = {2'b10, cp[11:6]};
        3'd2:    r = {2'b10, cp[17:12]};
        default: r = {2'b10, cp[5:0]};
      endcase
    end
    return r;
  endfunction

  always_comb begin
    if (head_i.cp < 21'h80) begin
      ncp = 3'd1;
    end else if (head_i.cp < 21'h800) begin
      ncp = 3'd2;
    end else if (head_i.cp < 21'h10000) begin
      ncp = 3'd3;
    end else begin
      ncp = 3'd4;
    end
  end

  assign cp_slots = head_i.cp_en ? ncp : 3'd0;
  assign total    = cp_slots + {2'b0, head_i.mid_en} + {2'b0, head_i.err_en};
  assign at_last  = (idx_q == total - 3'd1);

  always_comb begin
    res          = '0;
    res.run_last = at_last;
    if (idx_q < cp_slots) begin
      res.out_byte    = utf8_byte(head_i.cp, ncp, idx_q);
      res.result_kind = KIND_BYTE;
    end else if (head_i.mid_en && idx_q == cp_slots) begin
      res.out_byte    = head_i.mid_done ? 8'h00 : head_i.mid_byte;
      res.result_kind = head_i.mid_done ? KIND_DONE : KIND_BYTE;
    end else begin
      res.result_kind = KIND_ERR;
    end
  end

  assign pop_fire = pop_i && out_v_q;
  assign load     = stat_i.not_empty && (!out_v_q || pop_fire);
  assign deq_o    = load && at_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (load) begin
        out_v_q <= 1'b1;
        idx_q   <= at_last ? 3'd0 : idx_q + 3'd1;
      end else if (pop_fire) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign result_o    = out_q;

endmodule

`default_nettype wire

### rtl/core/json_string_unescape_utf8_unit.sv
// json string unescaper with utf-8 output
// input side is a queue: present item_i with push, it is taken on a clock
// edge with push high and full low; one text byte per item, text_end marks
// the last byte of the buffer
// result side is a queue: while empty is low, result_o holds the oldest
// result; pop high with empty low takes it
// each text byte gives zero to five results (decoded bytes, a completion
// or an error); run_last flags the final result of one byte
// with the expander idle, a taken byte is written into the queue, then its
// first result is registered onto result_o, from where it can be popped
// throughput: one text byte per cycle unless full, one result per cycle if
// popped; a byte with k results holds the expander until all k are out, the
// queue of QUEUE_DEPTH decoded entries between parser and expander absorbs
// those bursts; when the receiver stalls, the result register holds, the
// queue fills and full rises; the parser keeps its state until the next
// byte is taken; reset puts the parser in the seeking state and clears queue and output

`default_nettype none

`include "json_string_unescape_utf8_unit_assert.svh"

module json_string_unescape_utf8_unit import jsu_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire text_item_t item_i,
  output logic            empty,
  input  wire logic       pop,
  output result_item_t    result_o
);

  logic    accept, enq, deq, out_valid;
  bundle_t bnd, head;
  q_stat_t q_stat;

  assign accept = push && !q_stat.full;

  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .enq_o    (enq),
    .bundle_o (bnd)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .enq_i  (enq),
    .data_i (bnd),
    .deq_i  (deq),
    .head_o (head),
    .stat_o (q_stat)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (q_stat),
    .deq_o       (deq),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .result_o    (result_o)
  );

  assign full  = q_stat.full;
  assign empty = !out_valid;

  `JSU_ASSERT_NEXT(a_enq_lands, enq, q_stat.not_empty, "queued item went missing")
  `JSU_ASSERT_IMPL(a_deq_nonempty, deq, q_stat.not_empty, "dequeue from empty queue")
  `JSU_ASSERT_IMPL(a_end_is_last, (!empty && result_o.result_kind != KIND_BYTE),
                   result_o.run_last, "completion or error not last of its item")

endmodule

`default_nettype wire
